[design/sopg_pkg.sv]
`timescale 1ns / 1ps
// Package for the shape outline point generator: shape and status codes,
// the decoded job passed from front to back, and walk state types.
// No dependencies.
package sopg_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned CNT_W   = 5;

	typedef enum logic [2:0] {
		K_DOT    = 3'd0,
		K_HORZ   = 3'd1,
		K_VERT   = 3'd2,
		K_DIAG   = 3'd3,
		K_SQUARE = 3'd4,
		K_RECT   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SIDE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SIDE_RIGHT = 2'd0,
		SIDE_UP    = 2'd1,
		SIDE_LEFT  = 2'd2,
		SIDE_DOWN  = 2'd3
	} side_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_WALK = 1'b1
	} back_state_t;

	// Box: len_a = width-1, len_b = height-1. Line: len_a = point count.
	typedef struct packed {
		logic               is_box;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CNT_W-1:0]   len_a;
		logic [CNT_W-1:0]   len_b;
		logic               step_x;
		logic               step_y;
		status_t            status;
	} job_t;

endpackage

[design/sopg_front.sv]
`timescale 1ns / 1ps
// Front end: decodes one shape descriptor into a walk job (origin shift,
// length saturation, error and degenerate-box cases). Uses sopg_pkg.
module sopg_front #(
	parameter int unsigned MAX_LENGTH = 16
) (
	input  logic [2:0]         kind,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [5:0]  length_a,
	input  logic signed [5:0]  length_b,
	output sopg_pkg::job_t     job
);
	import sopg_pkg::*;

	function automatic logic [CNT_W-1:0] mag(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] m;
		begin
			m = v[LEN_W-1] ? (LEN_W'(0) - v) : v;
			if (m > LEN_W'(MAX_LENGTH))
				m = LEN_W'(MAX_LENGTH);
			mag = m[CNT_W-1:0];
		end
	endfunction

	logic [CNT_W-1:0]   a, b, w, h;
	logic               na, nb, box_req;
	logic [COORD_W-1:0] a_ext, b_ext, ox, oy;

	assign a     = mag(length_a);
	assign b     = mag(length_b);
	assign na    = length_a[LEN_W-1];
	assign nb    = length_b[LEN_W-1];
	assign a_ext = {{(COORD_W-CNT_W){1'b0}}, a};
	assign b_ext = {{(COORD_W-CNT_W){1'b0}}, b};

	always_comb begin
		job        = '0;
		job.len_a  = CNT_W'(1);
		job.status = ST_OK;
		ox         = start_x;
		oy         = start_y;
		w          = a;
		h          = a;
		box_req    = 1'b0;
		unique case (kind_t'(kind))
			K_RECT: begin
				if (a == '0 && b == '0) begin
					job.status = ST_ZERO;
					ox = '0;
					oy = '0;
				end else if (a == '0 || b == '0) begin
					job.status = ST_SIDE;
					ox = '0;
					oy = '0;
				end else begin
					box_req = 1'b1;
					h = b;
					if (na) ox = ox - a_ext;
					if (nb) oy = oy - b_ext;
				end
			end
			K_HORZ, K_VERT, K_DIAG, K_SQUARE: begin
				if (a == '0) begin
					job.status = ST_ZERO;
					ox = '0;
					oy = '0;
				end else begin
					job.len_a = a;
					unique case (kind_t'(kind))
						K_HORZ: begin
							job.step_x = 1'b1;
							if (na) ox = ox - a_ext;
						end
						K_VERT: begin
							job.step_y = 1'b1;
							if (na) oy = oy - a_ext;
						end
						K_DIAG: begin
							job.step_x = 1'b1;
							job.step_y = 1'b1;
							if (na) begin
								ox = ox - a_ext;
								oy = oy - a_ext;
							end
						end
						default: begin
							// square: only x moves back
							box_req = 1'b1;
							if (na) ox = ox - a_ext;
						end
					endcase
				end
			end
			default: ; // dot, and unknown kinds as a dot
		endcase

		if (box_req) begin
			if (h == CNT_W'(1)) begin
				job.len_a  = w;
				job.step_x = 1'b1;
			end else if (w == CNT_W'(1)) begin
				job.len_a  = h;
				job.step_y = 1'b1;
			end else begin
				job.is_box = 1'b1;
				job.len_a  = w - CNT_W'(1);
				job.len_b  = h - CNT_W'(1);
			end
		end
		job.x = ox;
		job.y = oy;
	end

endmodule

[design/sopg_queue.sv]
`timescale 1ns / 1ps
// Two-entry job queue between front and back.
// Uses sopg_pkg for the job type.
module sopg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sopg_pkg::job_t push_job,
	input  logic           pop,
	output sopg_pkg::job_t pop_job,
	output logic           empty,
	output logic           full
);
	import sopg_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

endmodule

[design/sopg_back.sv]
`timescale 1ns / 1ps
// Back end: walks one job a point per cycle, lines along a fixed step and
// boxes right, up, left, down. Uses sopg_pkg.
module sopg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sopg_pkg::job_t     job,
	input  logic               job_avail,
	output logic               pop,
	output logic               strobe,
	output logic signed [15:0] point_x,
	output logic signed [15:0] point_y,
	output logic [1:0]         status,
	output logic               last
);
	import sopg_pkg::*;

	back_state_t        state_q, state_d;
	logic [COORD_W-1:0] x_q, y_q, x_d, y_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d, wm1_q, hm1_q;
	side_t              side_q, side_d;
	logic               box_q, step_x_q, step_y_q;
	status_t            status_q;
	logic               load;

	assign strobe  = (state_q == BK_WALK);
	assign point_x = x_q;
	assign point_y = y_q;
	assign status  = status_q;
	assign last    = strobe && (cnt_q == CNT_W'(1)) && (!box_q || side_q == SIDE_DOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		x_d     = x_q;
		y_d     = y_q;
		cnt_d   = cnt_q;
		side_d  = side_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_avail) begin
					load    = 1'b1;
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				if (box_q) begin
					unique case (side_q)
						SIDE_RIGHT: x_d = x_q + COORD_W'(1);
						SIDE_UP:    y_d = y_q + COORD_W'(1);
						SIDE_LEFT:  x_d = x_q - COORD_W'(1);
						default:    y_d = y_q - COORD_W'(1);
					endcase
				end else begin
					x_d = x_q + COORD_W'(step_x_q);
					y_d = y_q + COORD_W'(step_y_q);
				end
				if (last) begin
					if (job_avail) load = 1'b1;
					else           state_d = BK_IDLE;
				end else if (cnt_q == CNT_W'(1)) begin
					// corner: next side takes over
					side_d = side_t'(side_q + 2'd1);
					cnt_d  = side_q[0] ? wm1_q : hm1_q;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			default: state_d = BK_IDLE;
		endcase
		if (load) begin
			x_d    = job.x;
			y_d    = job.y;
			cnt_d  = job.len_a;
			side_d = SIDE_RIGHT;
		end
	end

	assign pop = load;

	always_ff @(posedge clk) begin
		x_q    <= x_d;
		y_q    <= y_d;
		cnt_q  <= cnt_d;
		side_q <= side_d;
		if (load) begin
			box_q    <= job.is_box;
			wm1_q    <= job.len_a;
			hm1_q    <= job.len_b;
			step_x_q <= job.step_x;
			step_y_q <= job.step_y;
			status_q <= job.status;
		end
	end

endmodule

[design/shape_outline_point_generator_core.sv]
`timescale 1ns / 1ps
// Shape outline point generator, top level.
// Depends on sopg_pkg, sopg_front, sopg_queue and sopg_back.
//
// Input: a descriptor (kind, start_x, start_y, length_a, length_b) is taken
// on a rising edge with start high and busy low. The front decodes it in
// the same cycle into a two-entry queue; busy is high while that queue is
// full.
// Output: the back pops a job and walks it, one point per cycle on
// point_x/point_y/status with strobe high; last marks the final point of
// the descriptor. The receiver cannot stall: every strobed cycle is taken.
// With the back idle, an accepted item is registered in the queue, then
// loaded into the back's registers, and its first point is then on the
// ports. An item has 1 point for a dot or an error, up to 16 for a line
// and 2*(w-1)+2*(h-1) for a box, at most 60.
// Jobs follow each other with no gap while the queue holds the next one,
// so sustained throughput is set by the back's one-point-per-cycle walk.
// Reset (arst_n low) empties the queue and idles the back; an item being
// walked is dropped.
module shape_outline_point_generator_core #(
	parameter int unsigned MAX_LENGTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [5:0]  length_a,
	input  logic signed [5:0]  length_b,
	output logic               strobe,
	output logic signed [15:0] point_x,
	output logic signed [15:0] point_y,
	output logic [1:0]         status,
	output logic               last
);
	import sopg_pkg::*;

	job_t dec_job, head_job;
	logic q_empty, q_full, q_pop, accept;

	assign busy   = q_full;
	assign accept = start && !q_full;

	sopg_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.kind     (kind),
		.start_x  (start_x),
		.start_y  (start_y),
		.length_a (length_a),
		.length_b (length_b),
		.job      (dec_job)
	);

	sopg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (dec_job),
		.pop      (q_pop),
		.pop_job  (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	sopg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_avail (!q_empty),
		.pop       (q_pop),
		.strobe    (strobe),
		.point_x   (point_x),
		.point_y   (point_y),
		.status    (status),
		.last      (last)
	);

	// error results stand alone
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> last)
		else $error("error status on a result that is not last");

	// the points of one item come out without gaps
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside an item's outline");

	// busy only rises after an item was taken
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");

	// the back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for shape_outline_point_generator_core.
// Depends on sopg_pkg and the core; a scoreboard class predicts each outline
// point by point and checks the strobed results in order.
module testbench;
	import sopg_pkg::*;

	localparam int unsigned MAX_LEN = 16;
	localparam int unsigned N_RANDOM = 270;
	// Kind codes outside the package enum; the block treats them as a dot.
	localparam logic [2:0] K_SPARE_A = 3'd6;
	localparam logic [2:0] K_SPARE_B = 3'd7;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		status_t     st;
		logic        last;
	} outline_point_t;

	class outline_scoreboard;
		outline_point_t expected_points[$];
		outline_point_t walk_buf[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void push_point(logic [15:0] x, logic [15:0] y, status_t st);
			outline_point_t p;
			p.x = x;
			p.y = y;
			p.st = st;
			p.last = 1'b0;
			walk_buf.push_back(p);
		endfunction

		// Saturated magnitude of a 6-bit signed length.
		function int unsigned length_mag(logic [5:0] raw, output bit neg);
			int unsigned m;
			neg = raw[5];
			m = neg ? (64 - int'(raw)) : int'(raw);
			if (m > MAX_LEN)
				m = MAX_LEN;
			return m;
		endfunction

		function void walk_line(logic [15:0] x, logic [15:0] y, int unsigned n,
				int unsigned dx, int unsigned dy);
			for (int unsigned i = 0; i < n; i++)
				push_point(x + 16'(i * dx), y + 16'(i * dy), ST_OK);
		endfunction

		// Right, up, left, then down; a side of one collapses to a line.
		function void walk_box(logic [15:0] x, logic [15:0] y, int unsigned w,
				int unsigned h);
			if (h == 1) begin
				walk_line(x, y, w, 1, 0);
				return;
			end
			if (w == 1) begin
				walk_line(x, y, h, 0, 1);
				return;
			end
			for (int unsigned i = 0; i + 1 < w; i++)
				push_point(x + 16'(i), y, ST_OK);
			for (int unsigned i = 0; i + 1 < h; i++)
				push_point(x + 16'(w - 1), y + 16'(i), ST_OK);
			for (int i = int'(w) - 1; i >= 1; i--)
				push_point(x + 16'(i), y + 16'(h - 1), ST_OK);
			for (int i = int'(h) - 1; i >= 1; i--)
				push_point(x, y + 16'(i), ST_OK);
		endfunction

		function void add_shape(logic [2:0] k, logic [15:0] x, logic [15:0] y,
				logic [5:0] la, logic [5:0] lb);
			bit na, nb;
			int unsigned a, b;
			outline_point_t p;
			a = length_mag(la, na);
			b = length_mag(lb, nb);
			walk_buf.delete();
			if (k == K_RECT) begin
				if (a == 0 && b == 0)
					push_point(16'h0, 16'h0, ST_ZERO);
				else if (a == 0 || b == 0)
					push_point(16'h0, 16'h0, ST_SIDE);
				else begin
					if (na) x = x - 16'(a);
					if (nb) y = y - 16'(b);
					walk_box(x, y, a, b);
				end
			end else if (k != K_HORZ && k != K_VERT && k != K_DIAG && k != K_SQUARE) begin
				push_point(x, y, ST_OK);
			end else if (a == 0) begin
				push_point(16'h0, 16'h0, ST_ZERO);
			end else begin
				case (k)
					K_HORZ: begin
						if (na) x = x - 16'(a);
						walk_line(x, y, a, 1, 0);
					end
					K_VERT: begin
						if (na) y = y - 16'(a);
						walk_line(x, y, a, 0, 1);
					end
					K_DIAG: begin
						if (na) begin
							x = x - 16'(a);
							y = y - 16'(a);
						end
						walk_line(x, y, a, 1, 1);
					end
					default: begin
						// square: only x moves back
						if (na) x = x - 16'(a);
						walk_box(x, y, a, a);
					end
				endcase
			end
			p = walk_buf.pop_back();
			p.last = 1'b1;
			walk_buf.push_back(p);
			foreach (walk_buf[i])
				expected_points.push_back(walk_buf[i]);
		endfunction

		function void check_point(logic [15:0] px, logic [15:0] py, logic [1:0] st,
				logic lst);
			outline_point_t e;
			if (expected_points.size() == 0) begin
				$error("unexpected point (%0d, %0d) status %0d last %0d",
					$signed(px), $signed(py), st, lst);
				errors++;
				return;
			end
			e = expected_points.pop_front();
			if (px !== e.x) begin
				$error("point_x: expected %0d, got %0d", $signed(e.x), $signed(px));
				errors++;
			end
			if (py !== e.y) begin
				$error("point_y: expected %0d, got %0d", $signed(e.y), $signed(py));
				errors++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [15:0] start_x;
	logic [15:0] start_y;
	logic [5:0]  length_a;
	logic [5:0]  length_b;
	logic        strobe;
	logic [15:0] point_x;
	logic [15:0] point_y;
	logic [1:0]  status;
	logic        last;

	outline_scoreboard outlines;
	int no_gap_left;

	shape_outline_point_generator_core #(
		.MAX_LENGTH(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.start_x(start_x),
		.start_y(start_y),
		.length_a(length_a),
		.length_b(length_b),
		.strobe(strobe),
		.point_x(point_x),
		.point_y(point_y),
		.status(status),
		.last(last)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			outlines.check_point(point_x, point_y, status, last);
	end

	task automatic send_shape(input logic [2:0] k, input logic [15:0] x,
			input logic [15:0] y, input logic [5:0] a, input logic [5:0] b);
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		start_x <= x;
		start_y <= y;
		length_a <= a;
		length_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		outlines.add_shape(k, x, y, a, b);
	endtask

	// Fields carry noise while start is low; the block must ignore them.
	task automatic idle_input(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			kind <= 3'($urandom);
			start_x <= 16'($urandom);
			start_y <= 16'($urandom);
			length_a <= 6'($urandom);
			length_b <= 6'($urandom);
		end
	endtask

	// Mostly short gaps, a few long ones, and occasional back-to-back runs.
	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			no_gap_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 70);
	endfunction

	function automatic logic [15:0] pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h7FF8 + 16'($urandom_range(0, 15));
		if (r < 20)
			return 16'hFFF8 + 16'($urandom_range(0, 15));
		return 16'($urandom);
	endfunction

	function automatic logic [5:0] pick_length();
		int r;
		int m;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 6'd0;
		if (r < 14)
			return 6'($urandom_range(0, 63));
		if (r < 26)
			m = $urandom_range(13, 16);
		else
			m = $urandom_range(1, 6);
		return $urandom_range(0, 1) ? 6'(-m) : 6'(m);
	endfunction

	function automatic logic [2:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return K_DOT;
		if (r < 12)
			return $urandom_range(0, 1) ? K_SPARE_A : K_SPARE_B;
		if (r < 32)
			return K_RECT;
		if (r < 47)
			return K_SQUARE;
		if (r < 65)
			return K_HORZ;
		if (r < 83)
			return K_VERT;
		return K_DIAG;
	endfunction

	task automatic send_and_idle(input logic [2:0] k, input logic [15:0] x,
			input logic [15:0] y, input logic [5:0] a, input logic [5:0] b);
		send_shape(k, x, y, a, b);
		idle_input(pick_gap());
	endtask

	initial begin
		#400000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		outlines = new();
		no_gap_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = K_DOT;
		start_x = 16'h0;
		start_y = 16'h0;
		length_a = 6'h0;
		length_b = 6'h0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// dots and unused kinds: lengths ignored
		send_and_idle(K_DOT, 16'h7FFF, 16'h8000, 6'h1F, 6'h20);
		send_and_idle(K_SPARE_A, 16'h1234, 16'hABCD, 6'h05, 6'h05);
		send_and_idle(K_SPARE_B, 16'h0000, 16'hFFFF, 6'h00, 6'h00);
		// lines, full length, negative shift, wrap across the extremes
		send_and_idle(K_HORZ, 16'h7FF8, 16'h0010, 6'h10, 6'h00);
		send_and_idle(K_HORZ, 16'h8004, 16'hFFFF, 6'h30, 6'h3F);
		send_and_idle(K_VERT, 16'h0005, 16'hFFF8, 6'h10, 6'h00);
		send_and_idle(K_VERT, 16'h0000, 16'h8000, 6'h3F, 6'h00);
		send_and_idle(K_DIAG, 16'h0005, 16'h0005, 6'h30, 6'h00);
		send_and_idle(K_DIAG, 16'h7FFF, 16'h7FFF, 6'h1F, 6'h00);
		// zero length
		send_and_idle(K_HORZ, 16'h1111, 16'h2222, 6'h00, 6'h07);
		send_and_idle(K_VERT, 16'h1111, 16'h2222, 6'h00, 6'h00);
		send_and_idle(K_DIAG, 16'h1111, 16'h2222, 6'h00, 6'h00);
		send_and_idle(K_SQUARE, 16'h1111, 16'h2222, 6'h00, 6'h05);
		send_and_idle(K_RECT, 16'h1111, 16'h2222, 6'h00, 6'h00);
		// one rectangle side zero
		send_and_idle(K_RECT, 16'h1111, 16'h2222, 6'h00, 6'h05);
		send_and_idle(K_RECT, 16'h1111, 16'h2222, 6'h39, 6'h00);
		// sides of one
		send_and_idle(K_RECT, 16'h0100, 16'h0200, 6'h01, 6'h01);
		send_and_idle(K_RECT, 16'h0100, 16'h0200, 6'h01, 6'h07);
		send_and_idle(K_RECT, 16'h0100, 16'h0200, 6'h39, 6'h01);
		send_and_idle(K_SQUARE, 16'h0100, 16'h0200, 6'h01, 6'h00);
		// largest boxes, saturated lengths
		send_and_idle(K_RECT, 16'h7FF8, 16'h7FF8, 6'h10, 6'h10);
		send_and_idle(K_RECT, 16'h8000, 16'h0000, 6'h30, 6'h30);
		send_and_idle(K_SQUARE, 16'h0008, 16'h0008, 6'h30, 6'h3D);
		send_and_idle(K_SQUARE, 16'hFFF0, 16'hFFF0, 6'h20, 6'h00);
		send_and_idle(K_RECT, 16'h0000, 16'h0000, 6'h2F, 6'h03);

		for (int i = 0; i < N_RANDOM; i++)
			send_and_idle(pick_kind(), pick_coord(), pick_coord(), pick_length(),
				pick_length());

		@(negedge clk);
		start <= 1'b0;
		while (outlines.expected_points.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (outlines.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
